FILE: hw/rtl/swec_pkg.sv
// Shared types and constants for the sliding-window event counter.
package swec_pkg;

   localparam int ModeW   = 2;
   localparam int TimeW   = 48;
   localparam int AmountW = 32;
   localparam int CountW  = 64;
   localparam int CsrIdxW = 2;
   localparam int CsrDataW = 22;
   localparam int BucketMsW = 10;
   localparam int WinLenW   = 22;
   localparam int InUseW    = 7;

   localparam logic [ModeW-1:0] MODE_INC   = 2'd0;
   localparam logic [ModeW-1:0] MODE_QUERY = 2'd1;
   localparam logic [ModeW-1:0] MODE_CLEAR = 2'd2;

   localparam logic [CsrIdxW-1:0] REG_BUCKET_MS = 2'd0;
   localparam logic [CsrIdxW-1:0] REG_WIN_LEN   = 2'd1;
   localparam logic [CsrIdxW-1:0] REG_IN_USE    = 2'd2;

   localparam logic [BucketMsW-1:0] BUCKET_MS_RESET = 10'd100;
   localparam logic [WinLenW-1:0]   WIN_LEN_RESET   = 22'd1000;
   localparam logic [InUseW-1:0]    IN_USE_RESET    = 7'd10;

   typedef struct packed {
      logic [ModeW-1:0]   mode;
      logic [TimeW-1:0]   time_ms;
      logic [AmountW-1:0] amount;
   } req_type;

   typedef struct packed {
      logic [CountW-1:0] window_total;
      logic [CountW-1:0] lifetime_total;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;      // capture the request
      logic div_step;  // one quotient bit of time / bucket length
      logic mod_load;  // start period modulo buckets
      logic mod_step;  // one step of the modulo and of period * length
      logic inc_rd;    // read the chosen bucket
      logic inc_wr;    // write the chosen bucket
      logic clr_step;  // clear one bucket
      logic scan_rd;   // read bucket at scan index
      logic scan_acc;  // accumulate the read bucket
      logic idx_rst;   // restart the index counter
      logic idx_inc;   // advance the index counter
      logic rsp_load;  // load the result register
   } cmd_type;

   typedef struct packed {
      logic last_idx;  // index counter at its final count
   } sts_type;

endpackage

FILE: hw/rtl/swec_if.sv
// Valid/ready channel interfaces for requests, results and register writes.
interface swec_req_if;
   import swec_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface swec_rsp_if;
   import swec_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface swec_csr_if;
   import swec_pkg::*;
   logic                valid;
   logic                ready;
   logic [CsrIdxW-1:0]  index;
   logic [CsrDataW-1:0] wdata;
   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

FILE: hw/rtl/sliding_window_event_counter.sv
// Top level of the sliding-window event counter: registers, controller, datapath.
//
//   channel | direction | payload
//   req     | in        | mode, time_ms, amount
//   rsp     | out       | window_total, lifetime_total (query only)
//   csr     | in        | index, wdata (register write)
//
// Increment: capture, serial divide of time by bucket length, modulo/multiply walk,
// then a read and a write of the chosen bucket. Query: capture, a scan of all
// NumBuckets buckets, a final accumulate and the result load, plus result handoff.
// Clear: capture, then a sweep of every bucket, one bucket cleared a cycle.
// After reset a clearing pass zeroes every bucket while the input is held off.
// One item is in work at a time; a waiting result holds the input.
module sliding_window_event_counter #(
   parameter int NumBuckets = 64
) (
   input logic        clock,
   input logic        reset,
   swec_req_if.sink   req,
   swec_rsp_if.source rsp,
   swec_csr_if.sink   csr
);
   import swec_pkg::*;

   logic [BucketMsW-1:0] bucket_ms_ff;
   logic [WinLenW-1:0]   win_len_ff;
   logic [InUseW-1:0]    in_use_ff;
   cmd_type cmd;
   sts_type sts;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_ms_ff <= BUCKET_MS_RESET;
         win_len_ff   <= WIN_LEN_RESET;
         in_use_ff    <= IN_USE_RESET;
      end else if (csr.valid) begin
         unique case (csr.index)
            REG_BUCKET_MS: bucket_ms_ff <= csr.wdata[BucketMsW-1:0];
            REG_WIN_LEN:   win_len_ff   <= csr.wdata[WinLenW-1:0];
            REG_IN_USE:    in_use_ff    <= csr.wdata[InUseW-1:0];
            default: ;
         endcase
      end
   end

   swec_ctrl u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_mode(req.data.mode), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .sts, .cmd
   );

   swec_datapath #(.NumBuckets(NumBuckets)) u_dp (
      .clock, .reset,
      .req_data(req.data),
      .bucket_ms(bucket_ms_ff), .win_len(win_len_ff), .in_use(in_use_ff),
      .cmd, .sts, .rsp_data(rsp.data)
   );

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("result changed while stalled");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready)
      else $error("request taken while result pending");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.inc_wr, cmd.clr_step, cmd.scan_rd}))
      else $error("conflicting memory commands");
endmodule

FILE: hw/rtl/swec_datapath.sv
// Datapath: bucket memories, serial divider, modulo, multiplier and scan adder.
module swec_datapath #(
   parameter int NumBuckets = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  swec_pkg::req_type             req_data,
   input  logic [swec_pkg::BucketMsW-1:0] bucket_ms,
   input  logic [swec_pkg::WinLenW-1:0]  win_len,
   input  logic [swec_pkg::InUseW-1:0]   in_use,
   input  swec_pkg::cmd_type             cmd,
   output swec_pkg::sts_type             sts,
   output swec_pkg::rsp_type             rsp_data
);
   import swec_pkg::*;

   localparam int IdxW = (NumBuckets > 1) ? $clog2(NumBuckets) : 1;
   localparam int CntW = $clog2(NumBuckets + 1) > $clog2(TimeW + 1) ?
                         $clog2(NumBuckets + 1) : $clog2(TimeW + 1);
   localparam int NbW  = $clog2(NumBuckets + 1);

   logic [CountW-1:0] count_mem [NumBuckets];
   logic [TimeW-1:0]  stamp_mem [NumBuckets];

   req_type           req_ff;
   logic [CountW-1:0] lifetime_ff, lifetime_in;
   logic [TimeW-1:0]  quo_ff, rem_ff;        // divider; quo ends as period
   logic [TimeW-1:0]  mod_ff;                // period shifted during modulo
   logic [NbW-1:0]    modr_ff;               // modulo remainder
   logic [TimeW-1:0]  prod_ff;               // period * length (48-bit wrap)
   logic [CntW-1:0]   idx_ff;
   logic [IdxW-1:0]   bidx_ff;
   logic [CountW-1:0] rd_cnt_ff, sum_ff;
   logic [TimeW-1:0]  rd_stamp_ff;
   logic              rd_ok_ff;
   rsp_type           rsp_ff;

   logic [BucketMsW-1:0] len;
   logic [NbW-1:0]       nb;
   logic [TimeW:0]       rem_sh;
   logic [NbW:0]         modr_sh;
   logic [TimeW:0]       diff;
   logic [IdxW-1:0]      idx_lo;

   always_comb begin
      len = (bucket_ms == '0) ? BucketMsW'(1) : bucket_ms;
      if (in_use == '0) nb = NbW'(1);
      else if (32'(in_use) > NumBuckets) nb = NbW'(NumBuckets);
      else nb = NbW'(in_use);
      rem_sh  = {rem_ff, quo_ff[TimeW-1]};
      modr_sh = {modr_ff, mod_ff[TimeW-1]};
      // The extra top bit keeps a stamp later than the query time out of the window.
      diff    = {1'b0, req_ff.time_ms} - {1'b0, rd_stamp_ff};
      idx_lo  = idx_ff[IdxW-1:0];
      lifetime_in = lifetime_ff + CountW'(req_ff.amount);
   end

   // Index counter runs to TimeW for the divider and NumBuckets for sweeps.
   assign sts.last_idx = cmd.div_step || cmd.mod_step ?
                         (idx_ff == CntW'(TimeW - 1)) :
                         (idx_ff == CntW'(NumBuckets - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         lifetime_ff <= '0;
         idx_ff      <= '0;
      end else begin
         if (cmd.idx_rst) idx_ff <= '0;
         else if (cmd.idx_inc) idx_ff <= idx_ff + CntW'(1);
         if (cmd.clr_step && idx_ff == '0) lifetime_ff <= '0;
         if (cmd.inc_wr) lifetime_ff <= lifetime_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff   <= req_data;
         quo_ff   <= req_data.time_ms;
         rem_ff   <= '0;
         sum_ff   <= '0;
         rd_ok_ff <= 1'b0;
      end
      // Restoring division, one quotient bit a cycle.
      if (cmd.div_step) begin
         if (rem_sh >= (TimeW+1)'(len)) begin
            rem_ff <= TimeW'(rem_sh - (TimeW+1)'(len));
            quo_ff <= {quo_ff[TimeW-2:0], 1'b1};
         end else begin
            rem_ff <= TimeW'(rem_sh);
            quo_ff <= {quo_ff[TimeW-2:0], 1'b0};
         end
      end
      if (cmd.mod_load) begin
         mod_ff  <= quo_ff;
         modr_ff <= '0;
         prod_ff <= '0;
      end
      // Modulo and shift-add multiply share the same bit walk of the period.
      if (cmd.mod_step) begin
         mod_ff <= {mod_ff[TimeW-2:0], 1'b0};
         if (modr_sh >= (NbW+1)'(nb)) modr_ff <= NbW'(modr_sh - (NbW+1)'(nb));
         else modr_ff <= NbW'(modr_sh);
         prod_ff <= {prod_ff[TimeW-2:0], 1'b0} +
                    (mod_ff[TimeW-1] ? TimeW'(len) : '0);
      end
      if (cmd.inc_rd) begin
         bidx_ff     <= IdxW'(modr_ff);
         rd_cnt_ff   <= count_mem[IdxW'(modr_ff)];
         rd_stamp_ff <= stamp_mem[IdxW'(modr_ff)];
      end
      if (cmd.inc_wr) begin
         if (rd_stamp_ff < prod_ff) begin
            stamp_mem[bidx_ff] <= prod_ff;
            count_mem[bidx_ff] <= CountW'(req_ff.amount);
         end else begin
            count_mem[bidx_ff] <= rd_cnt_ff + CountW'(req_ff.amount);
         end
      end
      if (cmd.clr_step) begin
         count_mem[idx_lo] <= '0;
         stamp_mem[idx_lo] <= '0;
      end
      if (cmd.scan_rd) begin
         rd_cnt_ff   <= count_mem[idx_lo];
         rd_stamp_ff <= stamp_mem[idx_lo];
         rd_ok_ff    <= ({1'b0, idx_ff} < (CntW+1)'(nb));
      end
      if (cmd.scan_acc && rd_ok_ff && rd_stamp_ff != '0 &&
          diff < (TimeW+1)'(win_len))
         sum_ff <= sum_ff + rd_cnt_ff;
      if (cmd.rsp_load) begin
         rsp_ff.window_total   <= sum_ff;
         rsp_ff.lifetime_total <= lifetime_ff;
      end
   end

   assign rsp_data = rsp_ff;
endmodule

FILE: hw/rtl/swec_ctrl.sv
// Controller state machine sequencing the datapath for each request item.
module swec_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [swec_pkg::ModeW-1:0] req_mode,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  swec_pkg::sts_type      sts,
   output swec_pkg::cmd_type      cmd
);
   import swec_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DIV, S_MODLD, S_MOD, S_RD, S_WR, S_CLR, S_SCAN, S_LAST, S_RSP, S_WAIT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.load = accept;
            cmd.idx_rst = 1'b1;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cmd.idx_inc  = 1'b1;
         end
         S_MODLD: begin
            cmd.mod_load = 1'b1;
            cmd.idx_rst  = 1'b1;
         end
         S_MOD: begin
            cmd.mod_step = 1'b1;
            cmd.idx_inc  = 1'b1;
         end
         S_RD:   cmd.inc_rd = 1'b1;
         S_WR:   cmd.inc_wr = 1'b1;
         S_CLR: begin
            cmd.clr_step = 1'b1;
            cmd.idx_inc  = 1'b1;
         end
         S_SCAN: begin
            cmd.scan_rd  = 1'b1;
            cmd.scan_acc = 1'b1;
            cmd.idx_inc  = 1'b1;
         end
         S_LAST: cmd.scan_acc = 1'b1;
         S_RSP:  cmd.rsp_load = 1'b1;
         S_WAIT: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // Leaving reset runs one clearing pass over the bucket memories.
         state_ff     <= S_CLR;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE:
               if (accept) begin
                  unique case (req_mode)
                     MODE_INC:   state_ff <= S_DIV;
                     MODE_QUERY: state_ff <= S_SCAN;
                     MODE_CLEAR: state_ff <= S_CLR;
                     default:    state_ff <= S_IDLE;
                  endcase
               end
            S_DIV:   if (sts.last_idx) state_ff <= S_MODLD;
            S_MODLD: state_ff <= S_MOD;
            S_MOD:   if (sts.last_idx) state_ff <= S_RD;
            S_RD:    state_ff <= S_WR;
            S_WR:    state_ff <= S_IDLE;
            S_CLR:   if (sts.last_idx) state_ff <= S_IDLE;
            S_SCAN:  if (sts.last_idx) state_ff <= S_LAST;
            S_LAST:  state_ff <= S_RSP;
            S_RSP: begin
               state_ff     <= S_WAIT;
               rsp_valid_ff <= 1'b1;
            end
            S_WAIT:
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

FILE: verif/tb.sv
// Self-checking testbench for the sliding-window event counter.
module tb;
   import swec_pkg::*;

   localparam logic [ModeW-1:0] MODE_UNUSED = 2'd3;
   localparam int NumBkt      = 64;
   localparam int SettleCyc   = 200;
   localparam int CycleLimit  = 2000000;

   logic clock;
   logic reset;

   swec_req_if req ();
   swec_rsp_if rsp ();
   swec_csr_if csr ();

   sliding_window_event_counter #(.NumBuckets(NumBkt)) u_top (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source),
      .csr   (csr.sink)
   );

   // Predicted block state and register copies.
   logic [CountW-1:0]    ring_count [NumBkt];
   logic [TimeW-1:0]     ring_stamp [NumBkt];
   logic [CountW-1:0]    events_total;
   logic [BucketMsW-1:0] cfg_bucket_ms;
   logic [WinLenW-1:0]   cfg_win_len;
   logic [InUseW-1:0]    cfg_in_use;

   rsp_type pending_totals [$];
   int      errors;
   longint  cycles = 0;
   bit      quiet_phase;
   logic [TimeW-1:0] now_cursor;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("sliding_window_event_counter regression: fail");
         $finish;
      end
   end

   function automatic int live_buckets();
      if (cfg_in_use == 0) return 1;
      if (cfg_in_use > NumBkt) return NumBkt;
      return int'(cfg_in_use);
   endfunction

   // Applies one accepted item to the predicted state; queues totals for a query.
   task automatic predict_item(input req_type it);
      logic [63:0] len, period, idx, start, now, sum;
      begin
         now = {16'd0, it.time_ms};
         case (it.mode)
            MODE_INC: begin
               len    = (cfg_bucket_ms == 0) ? 64'd1 : {54'd0, cfg_bucket_ms};
               period = now / len;
               idx    = period % live_buckets();
               start  = period * len;
               if ({16'd0, ring_stamp[idx]} < start) begin
                  ring_stamp[idx] = start[TimeW-1:0];
                  ring_count[idx] = '0;
               end
               ring_count[idx] = ring_count[idx] + it.amount;
               events_total    = events_total + it.amount;
            end
            MODE_QUERY: begin
               sum = '0;
               for (int i = 0; i < live_buckets(); i++)
                  if (ring_stamp[i] != 0 &&
                      (now - {16'd0, ring_stamp[i]}) < {42'd0, cfg_win_len})
                     sum = sum + ring_count[i];
               pending_totals.push_back('{window_total: sum, lifetime_total: events_total});
            end
            MODE_CLEAR: begin
               for (int i = 0; i < NumBkt; i++) begin
                  ring_count[i] = '0;
                  ring_stamp[i] = '0;
               end
               events_total = '0;
            end
            default: ;
         endcase
      end
   endtask

   task automatic send_item(input logic [ModeW-1:0] mode, input logic [TimeW-1:0] t,
                            input logic [AmountW-1:0] amount);
      int gap;
      begin
         gap = quiet_phase ? 0 : $urandom_range(0, 18);
         if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req.valid        <= 1'b1;
         req.data.mode    <= mode;
         req.data.time_ms <= t;
         req.data.amount  <= amount;
         @(posedge clock);
         while (!req.ready) @(posedge clock);
         predict_item('{mode: mode, time_ms: t, amount: amount});
      end
   endtask

   // Waits for every expected result, then for the block to finish silent items.
   task automatic settle();
      req.valid <= 1'b0;
      while (pending_totals.size() != 0) @(posedge clock);
      repeat (SettleCyc) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrIdxW-1:0] index, input logic [CsrDataW-1:0] value);
      csr.valid <= 1'b1;
      csr.index <= index;
      csr.wdata <= value;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      case (index)
         REG_BUCKET_MS: cfg_bucket_ms = value[BucketMsW-1:0];
         REG_WIN_LEN:   cfg_win_len   = value[WinLenW-1:0];
         REG_IN_USE:    cfg_in_use    = value[InUseW-1:0];
         default: ;
      endcase
      csr.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input int bms, input int wms, input int inuse);
      settle();
      write_reg(REG_BUCKET_MS, CsrDataW'(bms));
      write_reg(REG_WIN_LEN, CsrDataW'(wms));
      write_reg(REG_IN_USE, CsrDataW'(inuse));
   endtask

   // Result side: random stalls, checked against the oldest expectation.
   initial begin
      int stall;
      rsp.ready = 1'b0;
      @(negedge reset);
      forever begin
         stall = quiet_phase ? 0 : $urandom_range(0, 18);
         if (stall > 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         @(posedge clock);
         while (!rsp.valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_totals.size() == 0) begin
            $error("result with no query outstanding");
            errors++;
         end else begin
            want = pending_totals.pop_front();
            if (rsp.data.window_total !== want.window_total) begin
               $error("window_total: expected %0d, actual %0d",
                      want.window_total, rsp.data.window_total);
               errors++;
            end
            if (rsp.data.lifetime_total !== want.lifetime_total) begin
               $error("lifetime_total: expected %0d, actual %0d",
                      want.lifetime_total, rsp.data.lifetime_total);
               errors++;
            end
         end
      end
   end

   task automatic test_directed();
      // The bucket store starts empty after reset.
      send_item(MODE_QUERY, 48'd500, '0);
      send_item(MODE_CLEAR, '0, '0);
      send_item(MODE_QUERY, '0, '0);
      send_item(MODE_INC, 48'd0, 32'hFFFF_FFFF);     // first period: stamp stays zero
      send_item(MODE_INC, 48'd150, 32'd5);
      send_item(MODE_INC, 48'd250, 32'hFFFF_FFFF);
      send_item(MODE_QUERY, 48'd300, '0);
      send_item(MODE_INC, 48'd120, 32'd3);           // time going backwards
      send_item(MODE_QUERY, 48'd50, '0);             // stamps later than query time
      send_item(MODE_UNUSED, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
      send_item(MODE_QUERY, 48'd1249, '0);
      send_item(MODE_QUERY, 48'd1250, '0);
      send_item(MODE_INC, 48'hFFFF_FFFF_FFFF, 32'h1234_5678);
      send_item(MODE_QUERY, 48'hFFFF_FFFF_FFFF, '0);
      send_item(MODE_CLEAR, 48'd7, 32'd9);
      send_item(MODE_QUERY, 48'hFFFF_FFFF_FFFF, '0);
      set_config(0, 0, 0);                           // zero length, zero window, zero in use
      send_item(MODE_INC, 48'd5, 32'd11);
      send_item(MODE_INC, 48'd6, 32'd12);
      send_item(MODE_QUERY, 48'd6, '0);
      set_config(1023, 4194303, 127);                // saturating bucket count
      send_item(MODE_INC, 48'd5000, 32'd1);
      send_item(MODE_INC, 48'd70000, 32'd2);
      send_item(MODE_QUERY, 48'd70000, '0);
      // A stamp near the top of the time range must not count for an early query.
      send_item(MODE_INC, 48'hFFFF_FFFF_FFF0, 32'd4);
      send_item(MODE_QUERY, 48'd10, '0);
      // Shrink the ring: data in buckets beyond the new count must be ignored.
      set_config(1023, 4194303, 1);
      send_item(MODE_QUERY, 48'd70000, '0);
   endtask

   task automatic run_phase(input int bms, input int wms, input int inuse, input int n);
      int sel, step;
      logic [ModeW-1:0]   mode;
      logic [AmountW-1:0] amount;
      begin
         set_config(bms, wms, inuse);
         step = (bms == 0) ? 3 : 3 * bms;
         for (int k = 0; k < n; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 5)
               now_cursor = {16'($urandom_range(0, 65535)), 32'($urandom)};
            else if (sel < 10)
               now_cursor = now_cursor - TimeW'($urandom_range(0, step));
            else
               now_cursor = now_cursor + TimeW'($urandom_range(0, step));
            sel = $urandom_range(0, 99);
            mode = (sel < 62) ? MODE_INC : (sel < 92) ? MODE_QUERY :
                   (sel < 95) ? MODE_CLEAR : MODE_UNUSED;
            amount = ($urandom_range(0, 3) == 0) ? 32'($urandom) : $urandom_range(0, 1000);
            send_item(mode, now_cursor, amount);
         end
      end
   endtask

   task automatic test_random();
      now_cursor = '0;
      run_phase(100, 1000, 10, 62);
      quiet_phase = 1'b1;
      run_phase(1, 1, 1, 62);
      quiet_phase = 1'b0;
      run_phase(1000, 3600000, 64, 62);
      run_phase(7, 50, 64, 62);
      quiet_phase = 1'b1;
      run_phase(3, 40, 13, 62);
      quiet_phase = 1'b0;
      run_phase($urandom_range(1, 1000), $urandom_range(1, 20000), $urandom_range(1, 64), 62);
      run_phase(1000, 4194303, 127, 62);
   endtask

   initial begin
      errors       = 0;
      quiet_phase  = 1'b0;
      cfg_bucket_ms = BUCKET_MS_RESET;
      cfg_win_len   = WIN_LEN_RESET;
      cfg_in_use    = IN_USE_RESET;
      events_total  = '0;
      for (int i = 0; i < NumBkt; i++) begin
         ring_count[i] = '0;
         ring_stamp[i] = '0;
      end
      reset     = 1'b1;
      req.valid = 1'b0;
      req.data  = '0;
      csr.valid = 1'b0;
      csr.index = '0;
      csr.wdata = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      settle();
      if (pending_totals.size() != 0) begin
         $error("%0d query results never arrived", pending_totals.size());
         errors++;
      end
      if (errors == 0)
         $display("sliding_window_event_counter regression: pass");
      else
         $display("sliding_window_event_counter regression: fail");
      $finish;
   end

endmodule
